// ===== src/rrsl_pkg.sv =====
// ----------------------------------------------------------------------------
// rrsl_pkg: shared types and constants of the ranked scan list
// Holds the item codes, the status codes, the stored entry layout and the
// byte mask used to zero SSID bytes beyond the length.
// ----------------------------------------------------------------------------
package rrsl_pkg;

  // Fixed SSID geometry: four 64-bit words, up to 32 bytes.
  localparam int unsigned SSID_BYTES = 32;
  localparam int unsigned SSID_BITS = 256;
  localparam int unsigned LEN_W = 6;
  localparam int unsigned RSSI_W = 8;

  // Default list depth.
  localparam int unsigned MAX_ENTRIES_DEF = 16;

  // Item operation codes.
  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  // Result status codes.
  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_BAD_SSID = 3'd1;
  localparam logic [2:0] ST_WEAK_DUP = 3'd2;
  localparam logic [2:0] ST_DROPPED = 3'd3;
  localparam logic [2:0] ST_CLEARED = 3'd4;
  localparam logic [2:0] ST_READ_OK = 3'd5;
  localparam logic [2:0] ST_READ_BAD = 3'd6;

  // One list entry as it sits in the entry memory.
  typedef struct packed {
    logic [SSID_BITS-1:0] ssid;
    logic [LEN_W-1:0] len;
    logic [RSSI_W-1:0] rssi;
  } entry_t;

  // Result of comparing one stored entry against the incoming key.
  typedef struct packed {
    logic same;  // Same SSID (length and bytes).
    logic ge;    // Stored RSSI is at least the key RSSI.
  } cmp_t;

  // Keeps the bytes below len and clears the rest.
  function automatic logic [SSID_BITS-1:0] ssid_mask(input logic [LEN_W-1:0] len);
    logic [SSID_BITS-1:0] m;
    m = '0;
    for (int b = 0; b < SSID_BYTES; b++) begin
      if (LEN_W'(b) < len) begin
        m[b*8 +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

endpackage

// ===== src/rrsl_cmp.sv =====
// ----------------------------------------------------------------------------
// rrsl_cmp: entry compare unit
// Compares one stored entry with the key of the add in progress: SSID
// identity (length and masked bytes) and signed RSSI order.
// ----------------------------------------------------------------------------
module rrsl_cmp (
  input  rrsl_pkg::entry_t                 ent_i,
  input  logic [rrsl_pkg::SSID_BITS-1:0]   key_ssid_i,
  input  logic [rrsl_pkg::LEN_W-1:0]       key_len_i,
  input  logic [rrsl_pkg::RSSI_W-1:0]      key_rssi_i,
  output rrsl_pkg::cmp_t                   res_o
);

  // Stored bytes beyond the length are zero, as are the key's, so a plain
  // word compare is enough once the lengths agree.
  always_comb begin
    res_o.same = (ent_i.len == key_len_i) && (ent_i.ssid == key_ssid_i);
    res_o.ge = $signed(ent_i.rssi) >= $signed(key_rssi_i);
  end

endmodule

// ===== src/rssi_ranked_scan_list.sv =====
// ----------------------------------------------------------------------------
// rssi_ranked_scan_list: access points ranked by RSSI, strongest first
// Adds, clears and reads a sorted list of SSID/RSSI entries kept in one
// entry memory, using a single compare unit under a small sequencer.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Bits  Contents
// s_axis    in   280   item: operation, SSID words, length, RSSI, read index
// m_axis    out  288   result: status, position, total, read entry
//
// An add with n stored entries is accepted and scans the n entries through
// the compare unit, then drains and decides (an add to an empty list goes
// straight to the decision); an insertion then moves entries down one slot,
// writes the new entry once the last moved entry has landed, and every add
// ends by loading the result. Clear and bad SSID go straight to loading the
// result, a read reads its entry first. The single read port sets these steps.
// Reset empties the list; the memory itself is not cleared. A result waiting
// on m_axis holds the sequencer in its last step until the beat is taken.
// ----------------------------------------------------------------------------
module rssi_ranked_scan_list #(
  parameter int unsigned MAX_ENTRIES = rrsl_pkg::MAX_ENTRIES_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [1:0] operation, [65:2] ssid_word0, [129:66] ssid_word1,
  // [193:130] ssid_word2, [257:194] ssid_word3, [263:258] ssid_len,
  // [271:264] signal_strength, [275:272] read_index, [279:276] zero
  input  logic [279:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [2:0] status, [6:3] position, [11:7] entry_total,
  // [75:12] out_ssid_word0, [139:76] out_ssid_word1,
  // [203:140] out_ssid_word2, [267:204] out_ssid_word3,
  // [273:268] out_ssid_len, [281:274] out_strength, [287:282] zero
  output logic [287:0] m_axis_tdata
);

  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned XW = (CW > 4) ? CW : 4;
  localparam int unsigned TW = (CW > 5) ? CW : 5;
  localparam logic [CW-1:0] MAX_C = CW'(MAX_ENTRIES);
  localparam logic [CW-1:0] LAST_C = CW'(MAX_ENTRIES - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_DECIDE = 3'd3;
  localparam logic [2:0] S_SHIFT = 3'd4;
  localparam logic [2:0] S_INSERT = 3'd5;
  localparam logic [2:0] S_READ = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0] state_q, state_d;
  logic [rrsl_pkg::SSID_BITS-1:0] key_ssid_q, key_ssid_d;
  logic [rrsl_pkg::LEN_W-1:0] key_len_q, key_len_d;
  logic [rrsl_pkg::RSSI_W-1:0] key_rssi_q, key_rssi_d;
  logic [3:0] idx_q, idx_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] ptr_q, ptr_d;
  logic cmp_v_q, cmp_v_d;
  logic [CW-1:0] cmp_i_q, cmp_i_d;
  logic dup_q, dup_d;
  logic dup_weak_q, dup_weak_d;
  logic [CW-1:0] dup_idx_q, dup_idx_d;
  logic [CW-1:0] ge_q, ge_d;
  logic pend_q, pend_d;
  logic [AW-1:0] pend_addr_q, pend_addr_d;
  logic [2:0] res_status_q, res_status_d;
  logic [3:0] res_pos_q, res_pos_d;
  logic m_valid_q, m_valid_d;
  logic [2:0] out_status_q, out_status_d;
  logic [3:0] out_pos_q, out_pos_d;
  logic [4:0] out_total_q, out_total_d;
  rrsl_pkg::entry_t out_ent_q, out_ent_d;

  // Entry memory: one write and one registered read per cycle.
  rrsl_pkg::entry_t mem_q [MAX_ENTRIES];
  rrsl_pkg::entry_t rd_q;
  logic we;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  rrsl_pkg::entry_t wdata;

  rrsl_pkg::cmp_t cmp;

  // Unpacked input beat.
  logic in_fire;
  logic [1:0] in_op;
  logic [rrsl_pkg::SSID_BITS-1:0] in_ssid;
  logic [rrsl_pkg::LEN_W-1:0] in_len;
  logic [rrsl_pkg::RSSI_W-1:0] in_rssi;
  logic [3:0] in_idx;

  // Width helpers for positions and counts.
  logic [XW-1:0] idx_x, in_idx_x, count_x, dup_pos_x, ge_pos_x;
  logic [TW-1:0] total_x;
  logic [CW-1:0] top, ptr_inc;

  assign in_op = s_axis_tdata[1:0];
  assign in_ssid = s_axis_tdata[257:2];
  assign in_len = s_axis_tdata[263:258];
  assign in_rssi = s_axis_tdata[271:264];
  assign in_idx = s_axis_tdata[275:272];

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire = s_axis_tvalid && s_axis_tready;

  assign idx_x = XW'(idx_q);
  assign in_idx_x = XW'(in_idx);
  assign count_x = XW'(count_q);
  assign dup_pos_x = XW'(dup_idx_q);
  assign ge_pos_x = XW'(ge_q);
  assign total_x = TW'(count_q);
  assign ptr_inc = ptr_q + CW'(1);
  assign top = dup_q ? dup_idx_q : ((count_q < MAX_C) ? count_q : LAST_C);

  // Shared compare unit, fed from the memory read register.
  rrsl_cmp u_cmp (
    .ent_i      (rd_q),
    .key_ssid_i (key_ssid_q),
    .key_len_i  (key_len_q),
    .key_rssi_i (key_rssi_q),
    .res_o      (cmp)
  );

  // Entry memory.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rd_q <= mem_q[raddr];
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    key_ssid_d = key_ssid_q;
    key_len_d = key_len_q;
    key_rssi_d = key_rssi_q;
    idx_d = idx_q;
    count_d = count_q;
    ptr_d = ptr_q;
    cmp_v_d = 1'b0;
    cmp_i_d = cmp_i_q;
    dup_d = dup_q;
    dup_weak_d = dup_weak_q;
    dup_idx_d = dup_idx_q;
    ge_d = ge_q;
    pend_d = 1'b0;
    pend_addr_d = pend_addr_q;
    res_status_d = res_status_q;
    res_pos_d = res_pos_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    out_status_d = out_status_q;
    out_pos_d = out_pos_q;
    out_total_d = out_total_q;
    out_ent_d = out_ent_q;
    raddr = idx_x[AW-1:0];
    we = 1'b0;
    waddr = pend_addr_q;
    wdata = rd_q;

    // A shifted entry read last cycle is written one slot further down.
    if (pend_q) begin
      we = 1'b1;
    end

    // Fold the compare of the entry read last cycle into the scan summary.
    if (cmp_v_q) begin
      if (cmp.same && !dup_q) begin
        dup_d = 1'b1;
        dup_idx_d = cmp_i_q;
        dup_weak_d = cmp.ge;
      end
      if (cmp.ge) begin
        ge_d = ge_q + CW'(1);
      end
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          key_ssid_d = in_ssid & rrsl_pkg::ssid_mask(in_len);
          key_len_d = in_len;
          key_rssi_d = in_rssi;
          idx_d = in_idx;
          ptr_d = '0;
          dup_d = 1'b0;
          dup_weak_d = 1'b0;
          ge_d = '0;
          res_pos_d = in_idx;
          unique case (in_op)
            rrsl_pkg::OP_ADD: begin
              res_pos_d = '0;
              if (in_len == '0 || in_len > rrsl_pkg::LEN_W'(rrsl_pkg::SSID_BYTES)) begin
                res_status_d = rrsl_pkg::ST_BAD_SSID;
                state_d = S_DONE;
              end else if (count_q == '0) begin
                state_d = S_DECIDE;
              end else begin
                state_d = S_SCAN;
              end
            end
            rrsl_pkg::OP_CLEAR: begin
              count_d = '0;
              res_pos_d = '0;
              res_status_d = rrsl_pkg::ST_CLEARED;
              state_d = S_DONE;
            end
            rrsl_pkg::OP_READ: begin
              if (in_idx_x < count_x) begin
                res_status_d = rrsl_pkg::ST_READ_OK;
                state_d = S_READ;
              end else begin
                res_status_d = rrsl_pkg::ST_READ_BAD;
                state_d = S_DONE;
              end
            end
            default: begin
              res_status_d = rrsl_pkg::ST_READ_BAD;
              state_d = S_DONE;
            end
          endcase
        end
      end

      // Walk every stored entry through the compare unit.
      S_SCAN: begin
        raddr = ptr_q[AW-1:0];
        cmp_v_d = 1'b1;
        cmp_i_d = ptr_q;
        if (ptr_q == count_q - CW'(1)) begin
          state_d = S_DRAIN;
        end else begin
          ptr_d = ptr_inc;
        end
      end

      S_DRAIN: begin
        state_d = S_DECIDE;
      end

      // Choose between weak duplicate, drop and insertion.
      S_DECIDE: begin
        if (dup_q && dup_weak_q) begin
          res_status_d = rrsl_pkg::ST_WEAK_DUP;
          res_pos_d = dup_pos_x[3:0];
          state_d = S_DONE;
        end else if (!dup_q && ge_q >= MAX_C) begin
          res_status_d = rrsl_pkg::ST_DROPPED;
          res_pos_d = '0;
          state_d = S_DONE;
        end else begin
          res_status_d = rrsl_pkg::ST_INSERTED;
          res_pos_d = ge_pos_x[3:0];
          if (!dup_q && count_q < MAX_C) begin
            count_d = count_q + CW'(1);
          end
          if (top > ge_q) begin
            ptr_d = top - CW'(1);
            state_d = S_SHIFT;
          end else begin
            state_d = S_INSERT;
          end
        end
      end

      // Move the entries from the insertion slot to the one below the top one slot down.
      S_SHIFT: begin
        raddr = ptr_q[AW-1:0];
        pend_d = 1'b1;
        pend_addr_d = ptr_inc[AW-1:0];
        if (ptr_q == ge_q) begin
          state_d = S_INSERT;
        end else begin
          ptr_d = ptr_q - CW'(1);
        end
      end

      // Write the new entry once the last shifted entry has landed.
      S_INSERT: begin
        if (!pend_q) begin
          we = 1'b1;
          waddr = ge_q[AW-1:0];
          wdata.ssid = key_ssid_q;
          wdata.len = key_len_q;
          wdata.rssi = key_rssi_q;
          state_d = S_DONE;
        end
      end

      S_READ: begin
        state_d = S_DONE;
      end

      // Load the output register when it is free.
      S_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          out_status_d = res_status_q;
          out_pos_d = res_pos_q;
          out_total_d = total_x[4:0];
          out_ent_d = (res_status_q == rrsl_pkg::ST_READ_OK) ? rd_q : '0;
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      key_ssid_q <= '0;
      key_len_q <= '0;
      key_rssi_q <= '0;
      idx_q <= '0;
      count_q <= '0;
      ptr_q <= '0;
      cmp_v_q <= 1'b0;
      cmp_i_q <= '0;
      dup_q <= 1'b0;
      dup_weak_q <= 1'b0;
      dup_idx_q <= '0;
      ge_q <= '0;
      pend_q <= 1'b0;
      pend_addr_q <= '0;
      res_status_q <= '0;
      res_pos_q <= '0;
      m_valid_q <= 1'b0;
      out_status_q <= '0;
      out_pos_q <= '0;
      out_total_q <= '0;
      out_ent_q <= '0;
    end else begin
      state_q <= state_d;
      key_ssid_q <= key_ssid_d;
      key_len_q <= key_len_d;
      key_rssi_q <= key_rssi_d;
      idx_q <= idx_d;
      count_q <= count_d;
      ptr_q <= ptr_d;
      cmp_v_q <= cmp_v_d;
      cmp_i_q <= cmp_i_d;
      dup_q <= dup_d;
      dup_weak_q <= dup_weak_d;
      dup_idx_q <= dup_idx_d;
      ge_q <= ge_d;
      pend_q <= pend_d;
      pend_addr_q <= pend_addr_d;
      res_status_q <= res_status_d;
      res_pos_q <= res_pos_d;
      m_valid_q <= m_valid_d;
      out_status_q <= out_status_d;
      out_pos_q <= out_pos_d;
      out_total_q <= out_total_d;
      out_ent_q <= out_ent_d;
    end
  end

  // Output beat.
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata = {6'd0, out_ent_q.rssi, out_ent_q.len, out_ent_q.ssid,
                         out_total_q, out_pos_q, out_status_q};

endmodule

// ===== test/tb_rssi_ranked_scan_list.sv =====
// ----------------------------------------------------------------------------
// tb_rssi_ranked_scan_list: self-checking bench for the ranked scan list
// Sends add, clear and read beats into the list, predicts each result beat
// with a behavioral copy of the sorted list, and compares every field of the
// results in order. Random gaps on both sides, plus one calm stretch.
// ----------------------------------------------------------------------------
module tb_rssi_ranked_scan_list;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LIST_DEPTH = rrsl_pkg::MAX_ENTRIES_DEF;
  // Unassigned operation code; the block answers it like a rejected read.
  localparam logic [1:0] OP_SPARE = 2'd3;

  // One item as the sender sees it.
  typedef struct packed {
    logic         drain_before;  // Wait for all results before sending.
    logic [1:0]   op;
    logic [255:0] ssid;
    logic [5:0]   len;
    logic [7:0]   rssi;
    logic [3:0]   idx;
  } scan_item_t;

  // One result beat, split into its fields.
  typedef struct packed {
    logic [2:0]   status;
    logic [3:0]   position;
    logic [4:0]   total;
    logic [255:0] ssid;
    logic [5:0]   len;
    logic [7:0]   rssi;
  } scan_report_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [279:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [287:0] m_axis_tdata;

  scan_item_t   scan_items[$];
  scan_report_t expected_reports[$];
  int unsigned  mismatches = 0;
  int unsigned  reports_seen = 0;
  logic         beat_in_taken = 1'b0;
  logic         calm;

  // Predicted list contents, strongest first.
  logic [255:0]       ap_ssid[LIST_DEPTH];
  logic [5:0]         ap_len[LIST_DEPTH];
  logic signed [7:0]  ap_rssi[LIST_DEPTH];
  int unsigned        ap_count = 0;

  rssi_ranked_scan_list dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #4 clk_i = ~clk_i;

  // No gaps on either side while this window of results passes.
  assign calm = (reports_seen >= 300) && (reports_seen < 420);

  // Keeps the first n bytes of an SSID.
  function automatic logic [255:0] len_mask(input logic [5:0] n);
    if (n >= 6'd32) begin
      return '1;
    end
    return (256'd1 << {n, 3'b000}) - 256'd1;
  endfunction

  function automatic logic [255:0] rand256();
    logic [255:0] v;
    for (int k = 0; k < 8; k++) begin
      v[k*32 +: 32] = $urandom;
    end
    return v;
  endfunction

  function automatic scan_item_t mk_item(input logic [1:0] op, input logic [255:0] ssid,
                                         input logic [5:0] len, input logic [7:0] rssi,
                                         input logic [3:0] idx);
    scan_item_t it;
    it.drain_before = 1'b0;
    it.op = op;
    it.ssid = ssid;
    it.len = len;
    it.rssi = rssi;
    it.idx = idx;
    return it;
  endfunction

  // Applies one item to the predicted list and returns the result it gives.
  function automatic scan_report_t rank_update(input scan_item_t it);
    scan_report_t      r;
    logic [255:0]      key;
    logic signed [7:0] level;
    int                cnt;
    int                slot;
    bit                settled;
    r = '0;
    settled = 1'b0;
    case (it.op)
      rrsl_pkg::OP_CLEAR: begin
        ap_count = 0;
        r.status = rrsl_pkg::ST_CLEARED;
      end
      rrsl_pkg::OP_ADD: begin
        if (it.len == 6'd0 || it.len > rrsl_pkg::SSID_BYTES) begin
          r.status = rrsl_pkg::ST_BAD_SSID;
        end else begin
          key = it.ssid & len_mask(it.len);
          level = it.rssi;
          cnt = ap_count;
          // Look for the same SSID; a stronger copy evicts the old entry.
          for (int i = 0; i < cnt; i++) begin
            if (ap_len[i] == it.len && ap_ssid[i] == key) begin
              if (level <= ap_rssi[i]) begin
                r.status = rrsl_pkg::ST_WEAK_DUP;
                r.position = i[3:0];
                settled = 1'b1;
              end else begin
                for (int m = i; m + 1 < cnt; m++) begin
                  ap_ssid[m] = ap_ssid[m+1];
                  ap_len[m] = ap_len[m+1];
                  ap_rssi[m] = ap_rssi[m+1];
                end
                cnt--;
              end
              break;
            end
          end
          if (!settled) begin
            // New entry goes after every entry of equal or higher RSSI.
            slot = 0;
            while (slot < cnt && ap_rssi[slot] >= level) begin
              slot++;
            end
            if (slot >= LIST_DEPTH) begin
              ap_count = cnt;
              r.status = rrsl_pkg::ST_DROPPED;
            end else begin
              if (cnt < LIST_DEPTH) begin
                cnt++;
              end
              for (int m = cnt - 1; m > slot; m--) begin
                ap_ssid[m] = ap_ssid[m-1];
                ap_len[m] = ap_len[m-1];
                ap_rssi[m] = ap_rssi[m-1];
              end
              ap_ssid[slot] = key;
              ap_len[slot] = it.len;
              ap_rssi[slot] = level;
              ap_count = cnt;
              r.status = rrsl_pkg::ST_INSERTED;
              r.position = slot[3:0];
            end
          end
        end
      end
      default: begin
        // Reads, and the spare code, which always reads as out of range.
        r.position = it.idx;
        if (it.op == rrsl_pkg::OP_READ && it.idx < ap_count) begin
          r.status = rrsl_pkg::ST_READ_OK;
          r.ssid = ap_ssid[it.idx];
          r.len = ap_len[it.idx];
          r.rssi = ap_rssi[it.idx];
        end else begin
          r.status = rrsl_pkg::ST_READ_BAD;
        end
      end
    endcase
    r.total = ap_count[4:0];
    return r;
  endfunction

  task automatic check_field(input string what, input logic [255:0] want,
                             input logic [255:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what, want, got);
      end
    end
  endtask

  // Sender: presents the next queued item at the falling edge.
  always @(negedge clk_i) begin : drive_items
    scan_item_t it;
    if (rst_ni) begin
      if (!s_axis_tvalid || beat_in_taken) begin
        if (scan_items.size() != 0
            && !(scan_items[0].drain_before && expected_reports.size() != 0)
            && (calm || $urandom_range(99) >= 14)) begin
          it = scan_items.pop_front();
          s_axis_tdata <= {4'b0, it.idx, it.rssi, it.len, it.ssid, it.op};
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= calm || ($urandom_range(99) >= 14);
    end
  end

  // Monitor: checks result beats, then predicts from accepted item beats.
  always @(posedge clk_i) begin : watch_beats
    scan_report_t got;
    scan_report_t want;
    scan_item_t   it;
    if (rst_ni) begin
      beat_in_taken <= s_axis_tvalid && s_axis_tready;
      if (m_axis_tvalid && m_axis_tready) begin
        got.status = m_axis_tdata[2:0];
        got.position = m_axis_tdata[6:3];
        got.total = m_axis_tdata[11:7];
        got.ssid = m_axis_tdata[267:12];
        got.len = m_axis_tdata[273:268];
        got.rssi = m_axis_tdata[281:274];
        if (expected_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t ns: result beat with none expected, data %0h", $time, m_axis_tdata);
          end
        end else begin
          want = expected_reports.pop_front();
          check_field("status", 256'(want.status), 256'(got.status));
          check_field("position", 256'(want.position), 256'(got.position));
          check_field("entry_total", 256'(want.total), 256'(got.total));
          check_field("out_ssid", want.ssid, got.ssid);
          check_field("out_ssid_len", 256'(want.len), 256'(got.len));
          check_field("out_strength", 256'(want.rssi), 256'(got.rssi));
        end
        reports_seen++;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        it = '0;
        it.op = s_axis_tdata[1:0];
        it.ssid = s_axis_tdata[257:2];
        it.len = s_axis_tdata[263:258];
        it.rssi = s_axis_tdata[271:264];
        it.idx = s_axis_tdata[275:272];
        expected_reports.push_back(rank_update(it));
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin : stimulus
    logic [255:0] pool_ssid[24];
    logic [5:0]   pool_len[24];
    logic [255:0] mask;
    logic [7:0]   level;
    scan_item_t   it;
    int unsigned  pick;
    int unsigned  p;

    // Directed: empty reads, bad lengths, ties, duplicates, length-only difference.
    scan_items.push_back(mk_item(rrsl_pkg::OP_READ, '0, 6'd0, 8'd0, 4'd0));
    scan_items.push_back(mk_item(rrsl_pkg::OP_ADD, '1, 6'd0, 8'h7F, 4'd0));
    scan_items.push_back(mk_item(rrsl_pkg::OP_ADD, '1, 6'd33, 8'h7F, 4'd0));
    scan_items.push_back(mk_item(rrsl_pkg::OP_ADD, '1, 6'd63, 8'h7F, 4'hF));
    scan_items.push_back(mk_item(rrsl_pkg::OP_ADD, '1, 6'd1, 8'h7F, 4'd0));
    scan_items.push_back(mk_item(rrsl_pkg::OP_ADD, '1, 6'd32, 8'h80, 4'd0));
    scan_items.push_back(mk_item(rrsl_pkg::OP_ADD, 256'hFF, 6'd1, 8'h7F, 4'd0));
    scan_items.push_back(mk_item(rrsl_pkg::OP_ADD, '1, 6'd32, 8'h00, 4'd0));
    scan_items.push_back(mk_item(rrsl_pkg::OP_ADD, '1, 6'd31, 8'h00, 4'd0));
    scan_items.push_back(mk_item(rrsl_pkg::OP_READ, '0, 6'd0, 8'd0, 4'd0));
    scan_items.push_back(mk_item(rrsl_pkg::OP_READ, '0, 6'd0, 8'd0, 4'd1));
    scan_items.push_back(mk_item(rrsl_pkg::OP_READ, '0, 6'd0, 8'd0, 4'd2));
    scan_items.push_back(mk_item(rrsl_pkg::OP_READ, '0, 6'd0, 8'd0, 4'd3));
    scan_items.push_back(mk_item(rrsl_pkg::OP_READ, '1, 6'h3F, 8'hFF, 4'd15));
    scan_items.push_back(mk_item(OP_SPARE, '0, 6'd0, 8'd0, 4'd1));
    scan_items.push_back(mk_item(rrsl_pkg::OP_ADD, '0, 6'd32, 8'h80, 4'd0));
    scan_items.push_back(mk_item(rrsl_pkg::OP_CLEAR, '0, 6'd0, 8'd0, 4'd0));
    scan_items.push_back(mk_item(rrsl_pkg::OP_READ, '0, 6'd0, 8'd0, 4'd0));

    // SSID pool; entry 2 repeats entry 0's bytes with a shorter length.
    for (int i = 0; i < 24; i++) begin
      pool_ssid[i] = rand256();
      pool_len[i] = 6'($urandom_range(32, 1));
    end
    pool_len[0] = 6'd32;
    pool_len[1] = 6'd1;
    pool_ssid[2] = pool_ssid[0];
    pool_len[2] = 6'd31;

    // Random part: mostly adds from the pool, so duplicates and full lists occur.
    for (int k = 0; k < 650; k++) begin
      pick = $urandom_range(199);
      level = ($urandom_range(1) != 0) ? 8'($urandom_range(12) - 60) : 8'($urandom);
      if (pick < 110) begin
        p = $urandom_range(23);
        mask = len_mask(pool_len[p]);
        it = mk_item(rrsl_pkg::OP_ADD, (pool_ssid[p] & mask) | (rand256() & ~mask),
                     pool_len[p], level, 4'($urandom));
      end else if (pick < 126) begin
        it = mk_item(rrsl_pkg::OP_ADD, rand256(), 6'($urandom_range(32, 1)), 8'($urandom),
                     4'($urandom));
      end else if (pick < 136) begin
        it = mk_item(rrsl_pkg::OP_ADD, rand256(),
                     ($urandom_range(1) != 0) ? 6'd0 : 6'($urandom_range(63, 33)),
                     8'($urandom), 4'($urandom));
      end else if (pick < 184) begin
        it = mk_item(rrsl_pkg::OP_READ, rand256(), 6'($urandom), 8'($urandom),
                     4'($urandom_range(15)));
      end else if (pick < 196) begin
        it = mk_item(OP_SPARE, rand256(), 6'($urandom), 8'($urandom), 4'($urandom));
      end else begin
        it = mk_item(rrsl_pkg::OP_CLEAR, rand256(), 6'($urandom), 8'($urandom),
                     4'($urandom));
      end
      it.drain_before = (k % 120 == 60);
      scan_items.push_back(it);
    end

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (scan_items.size() != 0 || s_axis_tvalid || expected_reports.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (80) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("rssi_ranked_scan_list verification clean");
    end else begin
      $display("rssi_ranked_scan_list verification failed");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin : watchdog
    #2_000_000;
    $display("rssi_ranked_scan_list verification failed");
    $finish;
  end

endmodule
